// ===== src/bffpa_pkg.sv =====
// Shared types and fixed constants of the bitmap first-fit page allocator.
// No dependencies; the top level refers to it by scoped names.
package bffpa_pkg;

   localparam int WORD_BITS  = 32;   // occupancy bits held in one map word
   localparam int BIT_IDX_W  = 5;    // index of a bit inside a map word
   localparam int PAGE_LOG2  = 12;   // 4 KiB pages
   localparam int SIZE_W     = 32;   // request size in bytes
   localparam int NEED_W     = 21;   // page count of a 32-bit byte size
   localparam int BYTES_W    = 41;   // byte counters
   localparam int ADDR_W     = 24;   // reported base address

   localparam logic [BYTES_W-1:0] TOTAL_RESET = 41'h0_8000_0000;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SREAD,
      ST_SCHECK,
      ST_SBIT,
      ST_MSETUP,
      ST_MREAD,
      ST_MWRITE,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

// ===== src/bffpa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bffpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bitmap_first_fit_page_allocator.sv =====
// Request to response: each map word is read and checked, a partly used word is walked bit
//   by bit; a grant marks the run by read-modify-write and updates the byte count. A request
//   of zero size or beyond the map skips the scan. A stalled response holds.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous; a clearing pass then rewrites each of the ceil(NUM_PAGES/32) map words
//   (first RESERVED_PAGES pages used) before the first request is taken.
module bitmap_first_fit_page_allocator #(
   parameter int NUM_PAGES      = 4096,
   parameter int RESERVED_PAGES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration: total managed bytes
   input  logic                                csr_wr_en,
   input  logic [bffpa_pkg::BYTES_W-1:0]       csr_wr_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bffpa_pkg::SIZE_W-1:0]        req_alloc_size,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic [bffpa_pkg::ADDR_W-1:0]        rsp_base_address,
   output logic [bffpa_pkg::BYTES_W-1:0]       rsp_free_bytes
);

   localparam int WB        = bffpa_pkg::WORD_BITS;
   localparam int BW        = bffpa_pkg::BIT_IDX_W;
   localparam int NUM_WORDS = (NUM_PAGES + WB - 1) / WB;
   localparam int WORD_AW   = $clog2(NUM_WORDS);
   localparam int START_W   = WORD_AW + BW;
   localparam int RUN_W     = START_W + 1;
   localparam int LAST_WORD = NUM_WORDS - 1;
   localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * WB;
   localparam int RES_FULL  = RESERVED_PAGES / WB;
   localparam int RES_REM   = RESERVED_PAGES % WB;

   localparam logic [63:0]   LAST_VALID64 = (64'd1 << LAST_BITS) - 64'd1;
   localparam logic [WB-1:0] LAST_VALID   = LAST_VALID64[WB-1:0];
   localparam logic [63:0]   RES_PART64   = (64'd1 << RES_REM) - 64'd1;
   localparam logic [WB-1:0] RES_PART     = RES_PART64[WB-1:0];
   localparam logic [WB-1:0] ONES         = '1;
   localparam logic [bffpa_pkg::BYTES_W-1:0] ALLOC_RESET =
      bffpa_pkg::BYTES_W'(64'(RESERVED_PAGES) << bffpa_pkg::PAGE_LOG2);

   bffpa_pkg::state_type state_ff, state_in;

   logic [WORD_AW-1:0]              word_ff, word_in;
   logic [BW-1:0]                   bit_ff, bit_in;
   logic [RUN_W-1:0]                run_ff, run_in;
   logic [RUN_W-1:0]                need_ff, need_in;
   logic [bffpa_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic [START_W-1:0]              start_ff, start_in;
   logic [START_W-1:0]              end_ff, end_in;
   logic [WB-1:0]                   shreg_ff, shreg_in;
   logic                            ok_ff, ok_in;
   logic [bffpa_pkg::BYTES_W-1:0]   alloc_ff, alloc_in;
   logic [bffpa_pkg::BYTES_W-1:0]   total_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [bffpa_pkg::ADDR_W-1:0]    rsp_base_ff, rsp_base_in;
   logic [bffpa_pkg::BYTES_W-1:0]   rsp_free_ff, rsp_free_in;

   // map RAM ports
   logic                            ram_wr_en;
   logic [WB-1:0]                   ram_wr_data;
   logic [WB-1:0]                   ram_rd_data;

   // shared datapath
   logic [RUN_W-1:0]                run_sum;
   logic [START_W-1:0]              pos;
   logic [START_W-1:0]              start_calc;
   logic [START_W-1:0]              end_calc;
   logic [bffpa_pkg::SIZE_W:0]      size_round;
   logic [bffpa_pkg::NEED_W-1:0]    need_full;
   logic [WB-1:0]                   map_word;
   logic [WB-1:0]                   clr_word;
   logic [WB-1:0]                   mark_mask;
   logic [BW-1:0]                   mark_lo, mark_hi;
   logic [bffpa_pkg::BYTES_W:0]     alloc_sum;
   logic [bffpa_pkg::BYTES_W-1:0]   free_calc;
   logic                            is_last_word;
   logic                            rsp_slot_free;

   bffpa_ram #(
      .WIDTH (WB),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ff),
      .wr_data (ram_wr_data),
      .rd_addr (word_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Shared datapath: one run adder, one position subtractor
   // ---------------------------------------------------------------
   assign is_last_word = (word_ff == WORD_AW'(LAST_WORD));

   // pages beyond the end of the map read as used
   assign map_word = ram_rd_data | (is_last_word ? ~LAST_VALID : '0);

   // add a whole word of free pages in the word check, one page in the bit walk
   assign run_sum = run_ff + ((state_ff == bffpa_pkg::ST_SCHECK) ? RUN_W'(WB) : RUN_W'(1));

   // run start: current page position minus pages already counted
   assign pos        = {word_ff, (state_ff == bffpa_pkg::ST_SBIT) ? bit_ff : BW'(0)};
   assign start_calc = pos - run_ff[START_W-1:0];
   assign end_calc   = start_ff + START_W'(need_ff - RUN_W'(1));

   // round the byte size up to pages
   assign size_round = {1'b0, req_alloc_size} + (bffpa_pkg::SIZE_W+1)'(12'hFFF);
   assign need_full  = size_round[bffpa_pkg::SIZE_W:bffpa_pkg::PAGE_LOG2];

   // reset image of the map: low RESERVED_PAGES bits set
   always_comb begin
      if (word_ff < WORD_AW'(RES_FULL)) begin
         clr_word = ONES;
      end else if (word_ff == WORD_AW'(RES_FULL)) begin
         clr_word = RES_PART;
      end else begin
         clr_word = '0;
      end
   end

   // bits of the current word that fall inside the claimed run
   assign mark_lo   = (word_ff == start_ff[START_W-1:BW]) ? start_ff[BW-1:0] : BW'(0);
   assign mark_hi   = (word_ff == end_ff[START_W-1:BW]) ? end_ff[BW-1:0] : BW'(WB - 1);
   assign mark_mask = (ONES << mark_lo) & (ONES >> (BW'(WB - 1) - mark_hi));

   // saturating byte count and clamped free count
   assign alloc_sum = {1'b0, alloc_ff} + (bffpa_pkg::BYTES_W+1)'(size_ff);
   assign free_calc = (total_ff > alloc_ff) ? (total_ff - alloc_ff) : '0;

   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      run_in       = run_ff;
      need_in      = need_ff;
      size_in      = size_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      shreg_in     = shreg_ff;
      ok_in        = ok_ff;
      alloc_in     = alloc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_free_in  = rsp_free_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = clr_word;

      case (state_ff)
         bffpa_pkg::ST_CLEAR: begin
            // rewrite the map one word a cycle
            ram_wr_en = 1'b1;
            if (is_last_word) begin
               word_in  = '0;
               state_in = bffpa_pkg::ST_IDLE;
            end else begin
               word_in = word_ff + WORD_AW'(1);
            end
         end

         bffpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               size_in = req_alloc_size;
               word_in = '0;
               bit_in  = '0;
               run_in  = '0;
               ok_in   = 1'b0;
               if (need_full == '0 ||
                   need_full > bffpa_pkg::NEED_W'(NUM_PAGES)) begin
                  // drop straight to a failed result
                  state_in = bffpa_pkg::ST_RESP;
               end else begin
                  need_in  = RUN_W'(need_full);
                  state_in = bffpa_pkg::ST_SREAD;
               end
            end
         end

         bffpa_pkg::ST_SREAD: begin
            bit_in   = '0;
            state_in = bffpa_pkg::ST_SCHECK;
         end

         bffpa_pkg::ST_SCHECK: begin
            if (map_word == ONES || map_word == '0) begin
               if (map_word == '0 && run_sum >= need_ff) begin
                  start_in = start_calc;
                  state_in = bffpa_pkg::ST_MSETUP;
               end else begin
                  run_in = (map_word == '0) ? run_sum : '0;
                  if (is_last_word) begin
                     state_in = bffpa_pkg::ST_RESP;
                  end else begin
                     word_in  = word_ff + WORD_AW'(1);
                     state_in = bffpa_pkg::ST_SREAD;
                  end
               end
            end else begin
               // mixed word: walk it bit by bit
               shreg_in = map_word;
               state_in = bffpa_pkg::ST_SBIT;
            end
         end

         bffpa_pkg::ST_SBIT: begin
            shreg_in = shreg_ff >> 1;
            bit_in   = bit_ff + BW'(1);
            if (!shreg_ff[0] && run_sum == need_ff) begin
               start_in = start_calc;
               state_in = bffpa_pkg::ST_MSETUP;
            end else begin
               run_in = shreg_ff[0] ? RUN_W'(0) : run_sum;
               if (bit_ff == BW'(WB - 1)) begin
                  if (is_last_word) begin
                     state_in = bffpa_pkg::ST_RESP;
                  end else begin
                     word_in  = word_ff + WORD_AW'(1);
                     state_in = bffpa_pkg::ST_SREAD;
                  end
               end
            end
         end

         bffpa_pkg::ST_MSETUP: begin
            end_in   = end_calc;
            word_in  = start_ff[START_W-1:BW];
            state_in = bffpa_pkg::ST_MREAD;
         end

         bffpa_pkg::ST_MREAD: begin
            state_in = bffpa_pkg::ST_MWRITE;
         end

         bffpa_pkg::ST_MWRITE: begin
            // read-modify-write: set the run bits, keep the rest
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data | mark_mask;
            if (word_ff == end_ff[START_W-1:BW]) begin
               state_in = bffpa_pkg::ST_UPDATE;
            end else begin
               word_in  = word_ff + WORD_AW'(1);
               state_in = bffpa_pkg::ST_MREAD;
            end
         end

         bffpa_pkg::ST_UPDATE: begin
            ok_in    = 1'b1;
            alloc_in = alloc_sum[bffpa_pkg::BYTES_W] ? '1 : alloc_sum[bffpa_pkg::BYTES_W-1:0];
            state_in = bffpa_pkg::ST_RESP;
         end

         bffpa_pkg::ST_RESP: begin
            // hold until the output register is free
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_base_in  = ok_ff ?
                  bffpa_pkg::ADDR_W'({start_ff, bffpa_pkg::PAGE_LOG2'(0)}) : '0;
               rsp_free_in  = free_calc;
               state_in     = bffpa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bffpa_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bffpa_pkg::ST_CLEAR;
         word_ff      <= '0;
         alloc_ff     <= ALLOC_RESET;
         total_ff     <= bffpa_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      run_ff      <= run_in;
      need_ff     <= need_in;
      size_ff     <= size_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      shreg_ff    <= shreg_in;
      ok_ff       <= ok_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_base_ff <= rsp_base_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign req_stall        = (state_ff != bffpa_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_base_address = rsp_base_ff;
   assign rsp_free_bytes   = rsp_free_ff;

`ifndef SYNTHESIS
   // a failed result never carries an address
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_base_ff == '0))
      else $error("failed transfer carries a base address");

   // the bit walk stops as soon as the run is long enough
   a_run_below_need: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bffpa_pkg::ST_SBIT) |-> (run_ff < need_ff))
      else $error("run count reached the need without stopping");

   // marking stays inside the words of the claimed run
   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bffpa_pkg::ST_MWRITE) |->
         (word_ff >= start_ff[START_W-1:BW] && word_ff <= end_ff[START_W-1:BW]))
      else $error("mark write outside the claimed run");

   // a claimed run was free in the map
   a_mark_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bffpa_pkg::ST_MWRITE) |-> ((ram_rd_data & mark_mask) == '0))
      else $error("claimed page was already used");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for bitmap_first_fit_page_allocator.
// Drives byte-size requests, predicts each grant from a bit-level page map copy and
// compares every response field. Depends on bffpa_pkg and the allocator RTL.
module testbench;

   localparam int NUM_PAGES      = 4096;
   localparam int RESERVED_PAGES = 64;
   localparam int PAGE_BYTES     = 4096;
   localparam int PAGE_LOG2      = bffpa_pkg::PAGE_LOG2;
   localparam int SIZE_W         = bffpa_pkg::SIZE_W;
   localparam int BYTES_W        = bffpa_pkg::BYTES_W;
   localparam int ADDR_W         = bffpa_pkg::ADDR_W;
   localparam int PHASE_ITEMS    = 120;     // random requests per managed total
   localparam int HOLD_CYCLES    = 150;     // one long receiver hold-off
   localparam int WATCHDOG_LIMIT = 20000;   // cycles without any transfer
   localparam int SETTLE_CYCLES  = 64;      // quiet time after the last response

   localparam logic [BYTES_W-1:0] BYTE_MAX    = '1;
   localparam logic [BYTES_W-1:0] TOTAL_RESET = bffpa_pkg::TOTAL_RESET;

   typedef struct packed {
      logic               ok;
      logic [ADDR_W-1:0]  base_address;
      logic [BYTES_W-1:0] free_bytes;
   } grant_type;

   // Drive every input to a known value from time zero.
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_wr_en      = 1'b0;
   logic [BYTES_W-1:0] csr_wr_data    = '0;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [SIZE_W-1:0]  req_alloc_size = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic               rsp_ok;
   logic [ADDR_W-1:0]  rsp_base_address;
   logic [BYTES_W-1:0] rsp_free_bytes;

   // Predictor state: page occupancy, claimed byte count, managed total.
   bit                 page_taken [NUM_PAGES];
   logic [BYTES_W-1:0] bytes_claimed;
   logic [BYTES_W-1:0] mem_total;

   logic [SIZE_W-1:0]  request_sizes [$];   // sizes waiting for the driver
   grant_type          pending_grants [$];  // predicted responses, oldest first
   grant_type          expected_grant;

   int requests_queued = 0;
   int requests_taken  = 0;
   int mismatch_count  = 0;
   int req_gap_left    = 0;
   int rsp_stall_left  = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;
   bit hold_armed      = 1'b0;
   bit hold_done       = 1'b0;
   bit quiet_tail      = 1'b0;

   always #5 clock = ~clock;

   bitmap_first_fit_page_allocator #(
      .NUM_PAGES      (NUM_PAGES),
      .RESERVED_PAGES (RESERVED_PAGES)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_alloc_size   (req_alloc_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_base_address (rsp_base_address),
      .rsp_free_bytes   (rsp_free_bytes)
   );

   // Round the size up to pages, claim the lowest free run that fits wholly inside
   // the map, bump the saturating byte count and report the clamped free count.
   function automatic grant_type predict_grant(input logic [SIZE_W-1:0] size);
      logic [SIZE_W:0]    page_count;
      logic [BYTES_W:0]   claim_sum;
      logic [31:0]        page_addr;
      int                 run_len;
      int                 first_page;
      bit                 found;
      grant_type          grant;
      page_count = ({1'b0, size} + (PAGE_BYTES - 1)) >> PAGE_LOG2;
      run_len    = 0;
      first_page = 0;
      found      = 1'b0;
      if (page_count != 0 && page_count <= NUM_PAGES) begin
         for (int p = 0; p < NUM_PAGES && !found; p++) begin
            if (page_taken[p]) begin
               run_len = 0;
            end else begin
               run_len++;
               if (run_len == page_count) begin
                  first_page = p + 1 - run_len;
                  found      = 1'b1;
               end
            end
         end
      end
      grant.ok           = found;
      grant.base_address = '0;
      if (found) begin
         for (int p = first_page; p < first_page + run_len; p++)
            page_taken[p] = 1'b1;
         claim_sum = {1'b0, bytes_claimed} + size;
         if (claim_sum > BYTE_MAX)
            bytes_claimed = BYTE_MAX;
         else
            bytes_claimed = claim_sum[BYTES_W-1:0];
         page_addr          = first_page * PAGE_BYTES;
         grant.base_address = page_addr[ADDR_W-1:0];
      end
      grant.free_bytes = (bytes_claimed >= mem_total) ? '0 : mem_total - bytes_claimed;
      return grant;
   endfunction

   task automatic report_mismatch(input string field, input logic [BYTES_W-1:0] seen,
                                  input logic [BYTES_W-1:0] wanted);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, seen, wanted);
      mismatch_count++;
   endtask

   task automatic enqueue_request(input logic [SIZE_W-1:0] size);
      request_sizes.push_back(size);
      requests_queued++;
   endtask

   // Sample on the falling edge so counters written at the rising edge are settled.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (requests_taken != requests_queued || pending_grants.size() != 0);
   endtask

   // Write the managed total only while no request is in flight.
   task automatic write_total(input logic [BYTES_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Request driver: hold the payload while stalled, advance on each transfer,
   // insert short random gaps except in the quiet tail.
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_gap_left != 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= $urandom_range(0, 3);
         end else if (request_sizes.size() != 0) begin
            req_valid      <= 1'b1;
            req_alloc_size <= request_sizes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: one long hold-off once armed (the block fills and stalls
   // its input meanwhile), otherwise random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         rsp_stall_left <= 0;
         hold_left      <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done && rsp_valid) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (rsp_stall_left != 0) begin
         rsp_stall      <= 1'b1;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_stall      <= 1'b1;
         rsp_stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: track config writes, predict on each request transfer, check each
   // response transfer against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PAGES; p++)
            page_taken[p] = (p < RESERVED_PAGES);
         bytes_claimed = BYTES_W'(RESERVED_PAGES * PAGE_BYTES);
         mem_total     = TOTAL_RESET;
      end else begin
         if (csr_wr_en)
            mem_total = csr_wr_data;
         // Check the response first: it always belongs to an earlier request.
         if (rsp_valid && !rsp_stall) begin
            if (pending_grants.size() == 0) begin
               report_mismatch("unrequested response (free_bytes)", rsp_free_bytes, '0);
            end else begin
               expected_grant = pending_grants.pop_front();
               if (rsp_ok !== expected_grant.ok)
                  report_mismatch("ok", BYTES_W'(rsp_ok), BYTES_W'(expected_grant.ok));
               if (rsp_base_address !== expected_grant.base_address)
                  report_mismatch("base_address", BYTES_W'(rsp_base_address),
                                  BYTES_W'(expected_grant.base_address));
               if (rsp_free_bytes !== expected_grant.free_bytes)
                  report_mismatch("free_bytes", rsp_free_bytes, expected_grant.free_bytes);
            end
         end
         if (req_valid && !req_stall) begin
            pending_grants.push_back(predict_grant(req_alloc_size));
            requests_taken++;
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [BYTES_W-1:0] total_value;
      logic [SIZE_W-1:0]  size;
      int                 free_pages;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero size, page edges, sizes beyond the map, all-ones and
      // alternating bit patterns. Runs with the managed total at its reset value.
      enqueue_request(32'h0000_0000);
      enqueue_request(32'h0000_0001);
      enqueue_request(32'h0000_0FFF);
      enqueue_request(32'h0000_1000);
      enqueue_request(32'h0000_1001);
      enqueue_request(32'h0000_6FFF);
      enqueue_request(32'hFFFF_FFFF);
      enqueue_request(32'h8000_0000);
      enqueue_request(32'h0100_0000);   // whole map: reserved pages block it
      enqueue_request(32'h0100_0001);   // one page more than the map
      enqueue_request(32'h00FC_0001);   // more pages than are still free
      enqueue_request(32'h5555_5555);
      enqueue_request(32'hAAAA_AAAA);
      enqueue_request(32'hFFFF_F000);
      enqueue_request(32'h0000_0000);
      enqueue_request(32'h0001_0000);
      wait_until_drained();

      // Random phases, one per managed total: zero (free count clamps), a value with
      // only the top bit set, a random value, and at or just above what is claimed.
      hold_armed = 1'b1;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: total_value = '0;
            1: total_value = 41'h100_0000_0000;
            2: begin
               total_value     = BYTES_W'({$urandom(), $urandom()});
               total_value[40] = 1'b0;
            end
            default: total_value = bytes_claimed + $urandom_range(0, 65536);
         endcase
         write_total(total_value);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Mostly small sizes that fit, so the map fills slowly over the run.
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: size = $urandom_range(1, 4 * PAGE_BYTES);
               5:             size = $urandom_range(1, 64 * PAGE_BYTES);
               6:             size = ($urandom_range(1, 16) << PAGE_LOG2)
                                     + $urandom_range(0, 2) - 1;
               7:             size = '0;
               8:             size = $urandom();
               default:       size = $urandom_range(32'h0100_0001, 32'hFFFF_FFFF);
            endcase
            enqueue_request(size);
         end
         wait_until_drained();
      end

      // Quiet tail: no idling. Ask for one page more than is free, then for all free pages,
      // which fills the map to its last page if they lie in one run, then for further sizes.
      quiet_tail = 1'b1;
      write_total(TOTAL_RESET);
      free_pages = 0;
      for (int p = 0; p < NUM_PAGES; p++)
         if (!page_taken[p])
            free_pages++;
      enqueue_request(free_pages * PAGE_BYTES + 1);
      if (free_pages != 0)
         enqueue_request(free_pages * PAGE_BYTES - (PAGE_BYTES - 1));
      enqueue_request(32'h0000_0001);
      enqueue_request(32'h0000_0000);
      for (int n = 0; n < 20; n++)
         enqueue_request((n % 2 == 0) ? $urandom() : $urandom_range(1, PAGE_BYTES));
      wait_until_drained();

      // Catch any response the block produces without a request.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== bitmap_first_fit_page_allocator.f =====
src/bffpa_pkg.sv
src/bffpa_ram.sv
src/bitmap_first_fit_page_allocator.sv
tb/testbench.sv
